### sv/msps_pkg.sv
// Shared types and constants for the Mode S fractional phase slicer.
// Used by the front, queue and back modules; depends on nothing.
package msps_pkg;

  // Decoupling queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Downlink format sets, one bit per DF value.
  localparam logic [31:0] DF_SHORT_SET = 32'h0000_0831;
  localparam logic [31:0] DF_LONG_SET  = 32'h0037_0000;
  localparam logic [3:0]  LONG_BYTES   = 4'd14;
  localparam logic [3:0]  SHORT_BYTES  = 4'd7;

  // Fractional phase values and sample steps.
  localparam logic [2:0] PHASE_LAST  = 3'd4;
  localparam logic [2:0] STEP_NORMAL = 3'd3;
  localparam logic [2:0] STEP_WRAP   = 3'd4;

  // Event handed from the front to the back: a restart marker, or a bit
  // decision point with the phase that selects the correlator.
  typedef struct packed {
    logic       is_start;
    logic [2:0] phase;
  } msps_evt_t;

  localparam int EVT_W = $bits(msps_evt_t);

endpackage

### sv/msps_front.sv
// Front of the slicer: shifts samples into the window and tracks skip,
// bit timing and fractional phase. Depends on msps_pkg.
module msps_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [SAMPLE_WIDTH-1:0]     sample,
  input  logic                        start_req,
  input  logic [3:0]                  trial_phase,
  output logic                        push,
  output msps_pkg::msps_evt_t         evt,
  output logic [4*SAMPLE_WIDTH-1:0]   window
);
  import msps_pkg::*;

  logic [4*SAMPLE_WIDTH-1:0] win_r, win_nxt;
  logic                      active_r, active_nxt;
  logic [1:0]                skip_r, skip_nxt;
  logic [2:0]                ste_r, ste_nxt;
  logic [2:0]                phase_r, phase_nxt;
  logic [1:0]                tp_skip;
  logic [3:0]                tp_rem;
  logic [2:0]                ste_dec;

  // Split the trial phase into a whole-sample skip and a remainder.
  always_comb begin
    if (trial_phase >= 4'd15) begin
      tp_skip = 2'd3;
    end else if (trial_phase >= 4'd10) begin
      tp_skip = 2'd2;
    end else if (trial_phase >= 4'd5) begin
      tp_skip = 2'd1;
    end else begin
      tp_skip = 2'd0;
    end
    tp_rem = trial_phase - {tp_skip, 2'b00} - {2'b00, tp_skip};
  end

  // Window shift and bit timing.
  always_comb begin
    win_nxt    = win_r;
    active_nxt = active_r;
    skip_nxt   = skip_r;
    ste_nxt    = ste_r;
    phase_nxt  = phase_r;
    push       = 1'b0;
    evt        = '{is_start: 1'b0, phase: phase_r};
    ste_dec    = ste_r - 3'd1;
    if (accept) begin
      win_nxt = {sample, win_r[4*SAMPLE_WIDTH-1:SAMPLE_WIDTH]};
      if (start_req) begin
        active_nxt = 1'b1;
        skip_nxt   = tp_skip;
        phase_nxt  = tp_rem[2:0];
        ste_nxt    = STEP_NORMAL;
        push       = 1'b1;
        evt        = '{is_start: 1'b1, phase: tp_rem[2:0]};
      end else if (active_r) begin
        if (skip_r != 2'd0) begin
          skip_nxt = skip_r - 2'd1;
        end else if (ste_dec != 3'd0) begin
          ste_nxt = ste_dec;
        end else begin
          push = 1'b1;
          if (phase_r >= PHASE_LAST) begin
            phase_nxt = 3'd0;
            ste_nxt   = STEP_WRAP;
          end else begin
            phase_nxt = phase_r + 3'd1;
            ste_nxt   = STEP_NORMAL;
          end
        end
      end
    end
  end

  // The event carries the window as it stands after this sample.
  assign window = win_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      active_r <= 1'b0;
      skip_r   <= 2'd0;
      ste_r    <= 3'd0;
      phase_r  <= 3'd0;
    end else begin
      win_r    <= win_nxt;
      active_r <= active_nxt;
      skip_r   <= skip_nxt;
      ste_r    <= ste_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

### sv/msps_queue.sv
// Short register queue that decouples the front from the back.
// Depends on msps_pkg for its depth.
module msps_queue #(
  parameter int WIDTH = 68
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty,
  output logic             not_full
);
  import msps_pkg::*;

  logic [WIDTH-1:0]  mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign not_empty = (count_r != QCNT_W'(0));
  assign not_full  = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

### sv/msps_back.sv
// Back of the slicer: correlator bit decision, byte assembly, DF check and
// the output register. Depends on msps_pkg.
module msps_back #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  msps_pkg::msps_evt_t         evt,
  input  logic [4*SAMPLE_WIDTH-1:0]   window,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  data_byte,
  output logic [3:0]                  byte_index,
  output logic                        last,
  output logic                        bad_format
);
  import msps_pkg::*;

  localparam int AW = SAMPLE_WIDTH + 6;
  localparam logic signed [AW-1:0] K2  = AW'(2);
  localparam logic signed [AW-1:0] K4  = AW'(4);
  localparam logic signed [AW-1:0] K6  = AW'(6);
  localparam logic signed [AW-1:0] K8  = AW'(8);
  localparam logic signed [AW-1:0] K10 = AW'(10);

  logic signed [AW-1:0] m0, m1, m2, m3, corr;
  logic                 bit_val;
  logic [7:0]           new_shift;

  logic       active_r, active_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] byte_cnt_r, byte_cnt_nxt;
  logic [3:0] msg_bytes_r, msg_bytes_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [3:0] out_idx_r, out_idx_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_bad_r, out_bad_nxt;
  logic [3:0] msg_sel;
  logic       bad, lastb;
  logic [4:0] df;

  // Window samples, oldest first, as non-negative signed values.
  assign m0 = signed'({{(AW-SAMPLE_WIDTH){1'b0}}, window[0*SAMPLE_WIDTH +: SAMPLE_WIDTH]});
  assign m1 = signed'({{(AW-SAMPLE_WIDTH){1'b0}}, window[1*SAMPLE_WIDTH +: SAMPLE_WIDTH]});
  assign m2 = signed'({{(AW-SAMPLE_WIDTH){1'b0}}, window[2*SAMPLE_WIDTH +: SAMPLE_WIDTH]});
  assign m3 = signed'({{(AW-SAMPLE_WIDTH){1'b0}}, window[3*SAMPLE_WIDTH +: SAMPLE_WIDTH]});

  // Weighted correlator picked by the fractional phase.
  always_comb begin
    case (evt.phase)
      3'd1:    corr = K8 * m0 + K6 * m1 - K10 * m2 - K4 * m3;
      3'd2:    corr = K6 * m0 + K10 * m1 - K10 * m2 - K6 * m3;
      3'd3:    corr = K4 * m0 + K10 * m1 - K6 * m2 - K8 * m3;
      3'd4:    corr = K2 * m0 + K10 * m1 - K2 * m2 - K10 * m3;
      default: corr = K10 * m0 + K2 * m1 - K10 * m2 - K2 * m3;
    endcase
  end

  assign bit_val   = (corr > AW'(signed'(0)));
  assign new_shift = {shift_r[6:0], bit_val};
  assign df        = new_shift[7:3];

  // Take an event only when the output register can hold a new byte.
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Byte assembly and message framing.
  always_comb begin
    active_nxt    = active_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    byte_cnt_nxt  = byte_cnt_r;
    msg_bytes_nxt = msg_bytes_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    msg_sel       = msg_bytes_r;
    bad           = 1'b0;
    lastb         = 1'b0;
    if (byte_cnt_r == 4'd0) begin
      if (DF_LONG_SET[df]) begin
        msg_sel = LONG_BYTES;
      end else if (DF_SHORT_SET[df]) begin
        msg_sel = SHORT_BYTES;
      end else begin
        bad = 1'b1;
      end
    end
    lastb = bad || (({1'b0, byte_cnt_r} + 5'd1) >= {1'b0, msg_sel});
    if (q_pop) begin
      if (evt.is_start) begin
        active_nxt    = 1'b1;
        bit_cnt_nxt   = 3'd0;
        shift_nxt     = 8'd0;
        byte_cnt_nxt  = 4'd0;
        msg_bytes_nxt = 4'd0;
      end else if (active_r) begin
        shift_nxt   = new_shift;
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = new_shift;
          out_idx_nxt   = byte_cnt_r;
          out_last_nxt  = lastb;
          out_bad_nxt   = bad;
          shift_nxt     = 8'd0;
          if (!bad) begin
            msg_bytes_nxt = msg_sel;
            byte_cnt_nxt  = byte_cnt_r + 4'd1;
          end
          if (lastb) begin
            active_nxt = 1'b0;
          end
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      bit_cnt_r   <= 3'd0;
      shift_r     <= 8'd0;
      byte_cnt_r  <= 4'd0;
      msg_bytes_r <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      msg_bytes_r <= msg_bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid  = out_valid_r;
  assign data_byte  = out_byte_r;
  assign byte_index = out_idx_r;
  assign last       = out_last_r;
  assign bad_format = out_bad_r;

`ifndef SYNTH
  // A rejected first byte always closes the message at position zero.
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_last_r && (out_idx_r == 4'd0))
    else $error("rejected byte not flagged last at index zero");

  // An accepted byte is last exactly when it fills the selected length.
  a_last_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bad_r |->
      (out_last_r == (({1'b0, out_idx_r} + 5'd1) == {1'b0, msg_bytes_r})))
    else $error("last flag disagrees with message length");

  // The queue is never drained while a held byte waits.
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid_r || out_ready))
    else $error("event taken while output stalled");
`endif

endmodule

### sv/mode_s_fractional_phase_slicer.sv
// Top level of the Mode S fractional phase slicer.
// Depends on msps_pkg, msps_front, msps_queue and msps_back.
//
// The slicer takes one magnitude sample per clock and emits sliced message
// bytes. A sample flagged with start_req (the first after the preamble)
// restarts slicing with the given trial phase; a partial message is dropped.
// The first byte's DF field picks a 7- or 14-byte message, and an unknown DF
// yields that byte with bad_format and tlast set. Rate: one sample per cycle
// sustained; the front pushes a bit event into a 4-entry queue and the back
// drains one event per cycle, so in_tready drops only when output stalls
// have filled that queue. When the queue and output register are empty, the
// event of the sample completing a byte's last bit is registered in the
// queue and then in the output register, which raises out_tvalid.
module mode_s_fractional_phase_slicer #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] sample, [19:16] trial_phase, rest zero
  input  logic        in_tuser,   // [0] start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [11:8] byte_index, rest zero
  output logic        out_tlast,
  output logic        out_tuser   // [0] bad_format
);
  import msps_pkg::*;

  localparam int WIN_W = 4 * SAMPLE_WIDTH;
  localparam int Q_W   = WIN_W + EVT_W;

  logic             accept, push, q_pop, q_valid, q_ready;
  msps_evt_t        f_evt, b_evt;
  logic [WIN_W-1:0] f_win, b_win;
  logic [Q_W-1:0]   q_out;
  logic [7:0]       data_byte;
  logic [3:0]       byte_index;

  assign in_tready = q_ready;
  assign accept    = in_tvalid && q_ready;

  msps_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .sample      (in_tdata[SAMPLE_WIDTH-1:0]),
    .start_req   (in_tuser),
    .trial_phase (in_tdata[19:16]),
    .push        (push),
    .evt         (f_evt),
    .window      (f_win)
  );

  msps_queue #(.WIDTH(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_evt, f_win}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid),
    .not_full  (q_ready)
  );

  assign b_evt = msps_evt_t'(q_out[Q_W-1:WIN_W]);
  assign b_win = q_out[WIN_W-1:0];

  msps_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .evt        (b_evt),
    .window     (b_win),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .data_byte  (data_byte),
    .byte_index (byte_index),
    .last       (out_tlast),
    .bad_format (out_tuser)
  );

  assign out_tdata = {4'd0, byte_index, data_byte};

endmodule

### bench/msps_checker.sv
// Scoreboard for the Mode S fractional phase slicer: predicts the sliced bytes
// from the accepted sample words and compares them with the output words.
// Depends on msps_pkg for the downlink format sets and the phase constants.
module msps_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] idx;
    logic       is_last;
    logic       bad;
  } slice_byte_t;

  // Bytes the slicer owes us, oldest first.
  slice_byte_t expected_bytes[$];

  // Slicer state as we model it.
  logic [15:0] win [4];
  logic [2:0]  phase;
  logic [1:0]  skip;
  logic [2:0]  bit_end;
  logic [2:0]  bit_cnt;
  logic [7:0]  shift_reg;
  logic [3:0]  byte_cnt;
  logic [3:0]  msg_len;
  logic        slicing;

  int err_cnt = 0;

  // Weighted correlator over the four-sample window; positive sum means a one.
  function automatic logic corr_bit(input logic [2:0] ph);
    int m0, m1, m2, m3, acc;
    m0 = int'(win[0]);
    m1 = int'(win[1]);
    m2 = int'(win[2]);
    m3 = int'(win[3]);
    case (ph)
      3'd1: acc = 8 * m0 + 6 * m1 - 10 * m2 - 4 * m3;
      3'd2: acc = 6 * m0 + 10 * m1 - 10 * m2 - 6 * m3;
      3'd3: acc = 4 * m0 + 10 * m1 - 6 * m2 - 8 * m3;
      3'd4: acc = 2 * m0 + 10 * m1 - 2 * m2 - 10 * m3;
      default: acc = 10 * m0 + 2 * m1 - 10 * m2 - 2 * m3;
    endcase
    return acc > 0;
  endfunction

  // Advance the model by one sample word and queue any byte it completes.
  task automatic slice_sample(input logic [15:0] s, input logic start, input logic [3:0] tp);
    slice_byte_t nb;
    logic [4:0]  df;
    logic        fin;
    win[0] = win[1];
    win[1] = win[2];
    win[2] = win[3];
    win[3] = s;

    // A start mark rearms the slicer and drops any partial message.
    if (start) begin
      slicing   = 1'b1;
      skip      = 2'(tp / 4'd5);
      phase     = 3'(tp % 4'd5);
      bit_end   = msps_pkg::STEP_NORMAL;
      bit_cnt   = '0;
      shift_reg = '0;
      byte_cnt  = '0;
      msg_len   = '0;
      return;
    end
    if (!slicing) return;
    if (skip != 0) begin
      skip = skip - 2'd1;
      return;
    end
    bit_end = bit_end - 3'd1;
    if (bit_end != 0) return;

    // Bit decision point: shift the bit in and step the fractional phase.
    shift_reg = {shift_reg[6:0], corr_bit(phase)};
    if (phase == msps_pkg::PHASE_LAST) begin
      phase   = '0;
      bit_end = msps_pkg::STEP_WRAP;
    end else begin
      phase   = phase + 3'd1;
      bit_end = msps_pkg::STEP_NORMAL;
    end
    bit_cnt = bit_cnt + 3'd1;
    if (bit_cnt != 0) return;

    // The first byte's DF picks the message length or rejects the message.
    if (byte_cnt == 0) begin
      df = shift_reg[7:3];
      if (msps_pkg::DF_LONG_SET[df]) begin
        msg_len = msps_pkg::LONG_BYTES;
      end else if (msps_pkg::DF_SHORT_SET[df]) begin
        msg_len = msps_pkg::SHORT_BYTES;
      end else begin
        nb.data    = shift_reg;
        nb.idx     = '0;
        nb.is_last = 1'b1;
        nb.bad     = 1'b1;
        expected_bytes.push_back(nb);
        slicing = 1'b0;
        return;
      end
    end
    fin        = (int'(byte_cnt) + 1) >= int'(msg_len);
    nb.data    = shift_reg;
    nb.idx     = byte_cnt;
    nb.is_last = fin;
    nb.bad     = 1'b0;
    expected_bytes.push_back(nb);
    byte_cnt  = byte_cnt + 4'd1;
    shift_reg = '0;
    if (fin) slicing = 1'b0;
  endtask

  // Compare output words first, since none can stem from this edge's sample.
  always @(posedge clk) begin
    slice_byte_t e;
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) win[k] = '0;
      phase     = '0;
      skip      = '0;
      bit_end   = '0;
      bit_cnt   = '0;
      shift_reg = '0;
      byte_cnt  = '0;
      msg_len   = '0;
      slicing   = 1'b0;
      expected_bytes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output word: data_byte %02h, byte_index %0d",
                 out_tdata[7:0], out_tdata[11:8]);
          err_cnt++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_tdata[7:0] !== e.data) begin
            $error("data_byte: expected %02h, got %02h", e.data, out_tdata[7:0]);
            err_cnt++;
          end
          if (out_tdata[11:8] !== e.idx) begin
            $error("byte_index: expected %0d, got %0d", e.idx, out_tdata[11:8]);
            err_cnt++;
          end
          if (out_tlast !== e.is_last) begin
            $error("last: expected %0b, got %0b", e.is_last, out_tlast);
            err_cnt++;
          end
          if (out_tuser !== e.bad) begin
            $error("bad_format: expected %0b, got %0b", e.bad, out_tuser);
            err_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        slice_sample(in_tdata[15:0], in_tuser, in_tdata[19:16]);
      end
    end
    fail_count <= err_cnt;
    pending    <= expected_bytes.size();
  end

endmodule

### bench/tb_mode_s_fractional_phase_slicer.sv
// Top of the slicer testbench: clock, reset, sample and receiver stimulus, verdict.
// Depends on msps_pkg, the mode_s_fractional_phase_slicer RTL and msps_checker.
module tb_mode_s_fractional_phase_slicer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MSG_SHORT  = 0;
  localparam int MSG_LONG   = 1;
  localparam int MSG_BAD_DF = 2;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [15:0] sample, [19:16] trial_phase, rest zero
  logic        in_tuser;   // [0] start_req
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] data_byte, [11:8] byte_index, rest zero
  logic        out_tlast;
  logic        out_tuser;  // [0] bad_format

  int fail_count;
  int pending;
  int n_items;
  bit sender_calm;

  mode_s_fractional_phase_slicer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  msps_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Draw a DF of the requested class from the package's format sets.
  function automatic logic [4:0] pick_df(input int kind);
    logic [4:0] df;
    int         k;
    do begin
      df = 5'($urandom_range(0, 31));
      k = msps_pkg::DF_LONG_SET[df] ? MSG_LONG :
          (msps_pkg::DF_SHORT_SET[df] ? MSG_SHORT : MSG_BAD_DF);
    end while (k != kind);
    return df;
  endfunction

  // Offer one sample word and hold it until the slicer takes it.
  task automatic push_sample(input logic [15:0] s, input logic start, input logic [3:0] tp);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, tp, s};
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    n_items++;
  endtask

  // Pulse-position waveform for a message, aligned near a random trial phase.
  // A cut shorter than the message leaves it unfinished for the next start.
  task automatic send_message(input logic [4:0] df, input int nbits, input int cut);
    logic [111:0] bits;
    logic [15:0]  s;
    int           tp, skew, nsamp, t5, chip, b;
    bits = 112'({$urandom, $urandom, $urandom, $urandom});
    bits[111:107] = df;
    tp = $urandom_range(0, 15);
    skew = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2)) - 1 : 0;
    nsamp = nbits * 16 / 5 + 5;
    if (cut > 0 && cut < nsamp) nsamp = cut;
    for (int n = 0; n < nsamp; n++) begin
      // Time in fifths of a sample from the start of bit 0; a chip is 1.6 samples.
      t5 = 5 * n - (tp + skew);
      chip = (t5 < 0) ? -1 : t5 / 8;
      b = chip / 2;
      if ($urandom_range(0, 19) == 0) begin
        s = 16'($urandom);
      end else if (chip >= 0 && b < nbits && (bits[111 - b] ^ chip[0])) begin
        s = 16'($urandom_range(12000, 65535));
      end else begin
        s = 16'($urandom_range(0, 3000));
      end
      push_sample(s, n == 0, (n == 0) ? 4'(tp) : 4'($urandom_range(0, 15)));
    end
  endtask

  // Receiver: random stalls with calm stretches, plus long hold-offs that
  // back the slicer up until it refuses samples.
  initial begin
    int cyc, stall, hold;
    bit calm;
    cyc   = 0;
    stall = 0;
    hold  = 0;
    calm  = 1'b0;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 300 == 0) calm = ($urandom_range(0, 2) == 0);
      if (cyc == 1500 || cyc == 4000) hold = 400;
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!calm) stall = pick_gap();
      end
    end
  end

  // Sample stimulus and verdict.
  initial begin
    int r;
    int len;
    n_items     = 0;
    sender_calm = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Idle samples pass through the window without any output.
    push_sample(16'h0000, 1'b0, 4'd0);
    push_sample(16'hFFFF, 1'b0, 4'd15);
    push_sample(16'h5A5A, 1'b0, 4'd10);
    // Trial phase fifteen skips three samples at phase zero.
    push_sample(16'hFFFF, 1'b1, 4'd15);
    push_sample(16'hFFFF, 1'b0, 4'd0);
    push_sample(16'h0000, 1'b0, 4'd0);
    push_sample(16'hFFFF, 1'b0, 4'd0);
    push_sample(16'h0000, 1'b0, 4'd0);
    // Starts while slicing restart on the spot, including back to back.
    push_sample(16'h8001, 1'b1, 4'd14);
    push_sample(16'h7FFE, 1'b1, 4'd4);
    push_sample(16'hFFFF, 1'b0, 4'd9);
    push_sample(16'h0000, 1'b0, 4'd5);
    push_sample(16'hFFFF, 1'b1, 4'd0);
    push_sample(16'h0000, 1'b0, 4'd0);
    push_sample(16'hFFFF, 1'b0, 4'd0);
    push_sample(16'h0000, 1'b0, 4'd0);
    push_sample(16'hFFFF, 1'b0, 4'd0);
    push_sample(16'h0000, 1'b0, 4'd0);

    // Mostly well-formed messages; some with a bad DF, some cut short, some noise.
    while (n_items < 1350) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_message(pick_df(MSG_SHORT), 56, 0);
      end else if (r < 70) begin
        send_message(pick_df(MSG_LONG), 112, 0);
      end else if (r < 80) begin
        send_message(pick_df(MSG_BAD_DF), 56, $urandom_range(28, 40));
      end else if (r < 90) begin
        send_message(pick_df($urandom_range(MSG_SHORT, MSG_LONG)), 112,
                     $urandom_range(1, 150));
      end else begin
        len = $urandom_range(1, 30);
        repeat (len) begin
          push_sample(16'($urandom), $urandom_range(0, 7) == 0, 4'($urandom_range(0, 15)));
        end
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain, then wait for any stray word.
    do @(negedge clk); while (pending != 0);
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
